[rtl/core/lsr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsr_pkg
// Shared widths, codes and controller/datapath interface types of the
// linear speed ramp setpoint generator.
// ----------------------------------------------------------------------------
package lsr_pkg;

	// default field widths
	localparam int SPEED_WIDTH  = 20;
	localparam int STEP_WIDTH   = 16;
	localparam int TIME_WIDTH   = 32;
	localparam int ACTION_WIDTH = 2;
	localparam int MODE_WIDTH   = 2;

	// action codes
	localparam logic [ACTION_WIDTH-1:0] ACT_UPDATE    = 2'd0;
	localparam logic [ACTION_WIDTH-1:0] ACT_RAMP_UP   = 2'd1;
	localparam logic [ACTION_WIDTH-1:0] ACT_RAMP_DOWN = 2'd2;

	// ramp modes
	localparam logic [MODE_WIDTH-1:0] MODE_IDLE = 2'd0;
	localparam logic [MODE_WIDTH-1:0] MODE_UP   = 2'd1;
	localparam logic [MODE_WIDTH-1:0] MODE_DOWN = 2'd2;

	// 0.1 rpm in raw units (rpm * 16), rounded down to one lsb
	localparam int OFF_LIMIT_RAW = 1;

	// controller -> datapath commands
	typedef struct packed {
		logic load_in;       // capture input word
		logic mul_en;        // product of delta and finished steps
		logic div_start;     // launch shared divider
		logic div_sel_step;  // divider operands: 1 ramp step, 0 step interval
		logic step_en;       // commit a ramp step
		logic start_en;      // commit a ramp start
		logic load_out;      // finish item, load result register
	} lsr_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic is_update;     // captured word is an update tick
		logic step_due;      // ramping and step interval elapsed
		logic start_ok;      // captured word is an acceptable start
		logic div_done;      // divider quotient ready
	} lsr_sts_t;

endpackage

[rtl/core/lsr_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsr_div
// Restoring unsigned divider, one quotient bit per cycle. The quotient is
// valid from the done pulse until the next start.
// ----------------------------------------------------------------------------
module lsr_div #(
	parameter int DVD_W = 36,
	parameter int DVS_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W+1:0] diff;
	logic             qbit;
	logic [DVS_W-1:0] rem_next;

	// trial subtraction of the divisor from the shifted remainder
	assign trial    = {rem_q, quo_q[DVD_W-1]};
	assign diff     = {1'b0, trial} - {2'b00, dvs_q};
	assign qbit     = ~diff[DVS_W+1];
	assign rem_next = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DVD_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/core/lsr_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsr_dp
// Ramp datapath: input capture, ramp state, step interpolation through one
// multiplier and the shared divider, and the result register.
// ----------------------------------------------------------------------------
module lsr_dp #(
	parameter int SPEED_WIDTH = lsr_pkg::SPEED_WIDTH,
	parameter int STEP_WIDTH  = lsr_pkg::STEP_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lsr_pkg::lsr_cmd_t                 cmd,
	output lsr_pkg::lsr_sts_t                 sts,
	input  logic [lsr_pkg::ACTION_WIDTH-1:0]  action,
	input  logic [SPEED_WIDTH-1:0]            target_rpm,
	input  logic [STEP_WIDTH-1:0]             step_count,
	input  logic [lsr_pkg::TIME_WIDTH-1:0]    ramp_time_ms,
	input  logic [SPEED_WIDTH-1:0]            measured_rpm,
	input  logic [lsr_pkg::TIME_WIDTH-1:0]    now_ms,
	output logic [SPEED_WIDTH-1:0]            setpoint_rpm,
	output logic                              motor_off,
	output logic [lsr_pkg::MODE_WIDTH-1:0]    ramp_mode,
	output logic                              start_accepted
);

	localparam int TW     = lsr_pkg::TIME_WIDTH;
	localparam int PROD_W = SPEED_WIDTH + STEP_WIDTH;
	localparam int DVD_W  = (TW > PROD_W) ? TW : PROD_W;

	localparam logic [SPEED_WIDTH-1:0] OFF_LIMIT = SPEED_WIDTH'(lsr_pkg::OFF_LIMIT_RAW);

	// captured input word
	logic [lsr_pkg::ACTION_WIDTH-1:0] action_q;
	logic [SPEED_WIDTH-1:0]           target_q;
	logic [STEP_WIDTH-1:0]            steps_q;
	logic [TW-1:0]                    ramp_q;
	logic [SPEED_WIDTH-1:0]           measured_q;
	logic [TW-1:0]                    now_q;

	// ramp state
	logic [lsr_pkg::MODE_WIDTH-1:0] mode_q;
	logic [SPEED_WIDTH-1:0]         goal_q;
	logic [SPEED_WIDTH-1:0]         origin_q;
	logic [SPEED_WIDTH-1:0]         held_q;
	logic [STEP_WIDTH-1:0]          total_q;
	logic [STEP_WIDTH-1:0]          finished_q;
	logic [TW-1:0]                  interval_q;
	logic [TW-1:0]                  last_q;
	logic                           dir_up_q;
	logic [SPEED_WIDTH-1:0]         delta_q;
	logic                           accepted_q;

	// step product
	logic [PROD_W-1:0] prod_s1;

	// result register
	logic [SPEED_WIDTH-1:0]         sp_out_q;
	logic                           off_out_q;
	logic [lsr_pkg::MODE_WIDTH-1:0] mode_out_q;
	logic                           acc_out_q;

	// divider
	logic [DVD_W-1:0]      div_dividend;
	logic [STEP_WIDTH-1:0] div_divisor;
	logic                  div_done;
	logic [DVD_W-1:0]      div_quo;

	logic [TW-1:0]          elapsed;
	logic                   is_update;
	logic                   is_start;
	logic [SPEED_WIDTH-1:0] q_spd;
	logic [SPEED_WIDTH-1:0] rpm_raw;
	logic [SPEED_WIDTH-1:0] rpm_clamp;
	logic [STEP_WIDTH-1:0]  fin_next;
	logic                   last_step;
	logic [SPEED_WIDTH-1:0] snap_sp;
	logic [SPEED_WIDTH-1:0] sp_fin;
	logic                   off_fin;

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			action_q   <= action;
			target_q   <= target_rpm;
			steps_q    <= step_count;
			ramp_q     <= ramp_time_ms;
			measured_q <= measured_rpm;
			now_q      <= now_ms;
		end
	end

	// decode and step timing
	assign is_update = (action_q == lsr_pkg::ACT_UPDATE);
	assign is_start  = (action_q == lsr_pkg::ACT_RAMP_UP) || (action_q == lsr_pkg::ACT_RAMP_DOWN);
	assign elapsed   = now_q - last_q;

	assign sts.is_update = is_update;
	assign sts.step_due  = (mode_q != lsr_pkg::MODE_IDLE) && (elapsed >= interval_q);
	assign sts.start_ok  = is_start && (mode_q == lsr_pkg::MODE_IDLE) &&
	                       (steps_q != '0) && (ramp_q != '0);
	assign sts.div_done  = div_done;

	// delta * finished, registered ahead of the divide
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= delta_q * finished_q;
		end
	end

	// shared divider: step interval on start, interpolation on a step
	assign div_dividend = cmd.div_sel_step ? DVD_W'(prod_s1) : DVD_W'(ramp_q);
	assign div_divisor  = cmd.div_sel_step ? total_q : steps_q;

	lsr_div #(
		.DVD_W(DVD_W),
		.DVS_W(STEP_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// interpolated setpoint, clamped to the goal in the ramp direction
	assign q_spd   = div_quo[SPEED_WIDTH-1:0];
	assign rpm_raw = dir_up_q ? (origin_q + q_spd) : (origin_q - q_spd);

	always_comb begin
		rpm_clamp = rpm_raw;
		if (mode_q == lsr_pkg::MODE_UP && rpm_raw > goal_q) begin
			rpm_clamp = goal_q;
		end
		if (mode_q == lsr_pkg::MODE_DOWN && rpm_raw < goal_q) begin
			rpm_clamp = goal_q;
		end
	end

	assign fin_next  = finished_q + 1'b1;
	assign last_step = (fin_next >= total_q);
	// ramp down ending below 0.1 rpm settles at zero
	assign snap_sp   = (mode_q == lsr_pkg::MODE_DOWN && goal_q <= OFF_LIMIT) ? '0 : goal_q;

	// reported setpoint
	assign sp_fin  = (is_update && mode_q == lsr_pkg::MODE_IDLE) ? target_q : held_q;
	assign off_fin = (sp_fin <= OFF_LIMIT);

	// ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= lsr_pkg::MODE_IDLE;
			goal_q     <= '0;
			origin_q   <= '0;
			held_q     <= '0;
			total_q    <= '0;
			finished_q <= '0;
			interval_q <= '0;
			last_q     <= '0;
			dir_up_q   <= 1'b0;
			delta_q    <= '0;
			accepted_q <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				accepted_q <= 1'b0;
			end
			if (cmd.start_en) begin
				mode_q     <= (action_q == lsr_pkg::ACT_RAMP_UP) ?
				              lsr_pkg::MODE_UP : lsr_pkg::MODE_DOWN;
				goal_q     <= target_q;
				origin_q   <= measured_q;
				held_q     <= measured_q;
				total_q    <= steps_q;
				interval_q <= div_quo[TW-1:0];
				last_q     <= now_q;
				finished_q <= '0;
				dir_up_q   <= (target_q >= measured_q);
				delta_q    <= (target_q >= measured_q) ? (target_q - measured_q) :
				              (measured_q - target_q);
				accepted_q <= 1'b1;
			end
			if (cmd.step_en) begin
				last_q     <= now_q;
				finished_q <= fin_next;
				if (last_step) begin
					held_q <= snap_sp;
					mode_q <= lsr_pkg::MODE_IDLE;
				end else begin
					held_q <= rpm_clamp;
				end
			end
			// update tick: idle pass-through and motor-off hold clear
			if (cmd.load_out && is_update) begin
				if (mode_q == lsr_pkg::MODE_IDLE) begin
					goal_q <= target_q;
				end
				if (off_fin) begin
					held_q <= '0;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			sp_out_q   <= sp_fin;
			off_out_q  <= off_fin;
			mode_out_q <= mode_q;
			acc_out_q  <= accepted_q;
		end
	end

	assign setpoint_rpm   = sp_out_q;
	assign motor_off      = off_out_q;
	assign ramp_mode      = mode_out_q;
	assign start_accepted = acc_out_q;

endmodule

[rtl/core/lsr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsr_ctrl
// Item sequencer: accepts a word, runs the step or start sequence on the
// datapath and hands the result to the output register.
// ----------------------------------------------------------------------------
module lsr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output lsr_pkg::lsr_cmd_t cmd,
	input  lsr_pkg::lsr_sts_t sts
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVAL  = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_DIVGO = 3'd3;
	localparam logic [2:0] ST_WAIT  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       step_q;
	logic       out_valid_q;
	logic       out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.is_update && sts.step_due) begin
					state_d = ST_MUL;
				end else if (sts.start_ok) begin
					cmd.div_start = 1'b1;
					state_d       = ST_WAIT;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_DIVGO;
			end
			ST_DIVGO: begin
				cmd.div_start    = 1'b1;
				cmd.div_sel_step = 1'b1;
				state_d          = ST_WAIT;
			end
			ST_WAIT: begin
				if (sts.div_done) begin
					cmd.step_en  = step_q;
					cmd.start_en = !step_q;
					state_d      = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, divide kind and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EVAL) begin
				step_q <= sts.is_update && sts.step_due;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/linear_speed_ramp_setpoint.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_speed_ramp_setpoint
// Linear motor speed setpoint ramp: start words latch a ramp, update ticks
// step it through time and report the setpoint for the speed loop.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | contents
//  s_*      | in  | s_tvalid/s_tready  | tuser action, tdata ramp and time word
//  m_*      | out | m_tvalid/m_tready  | tdata setpoint, off flag, mode, accept
//
//  A ramp step runs the multiplier and then the shared divider, an accepted
//  start runs the divider alone and any other word goes straight to the result
//  register. The divider works on DVD_W bits, the wider of 32 and SPEED_WIDTH +
//  STEP_WIDTH (36 at default widths), one quotient bit per cycle. One word is in
//  work at a time. The result register lets a new word be taken while a result
//  waits; a finished word holds until the register is free. Reset clears the
//  ramp to idle with all speeds and times at zero.
// ----------------------------------------------------------------------------
module linear_speed_ramp_setpoint #(
	parameter int SPEED_WIDTH = lsr_pkg::SPEED_WIDTH,
	parameter int STEP_WIDTH  = lsr_pkg::STEP_WIDTH,
	localparam int IN_BITS    = 3 * lsr_pkg::TIME_WIDTH - lsr_pkg::TIME_WIDTH +
	                            2 * SPEED_WIDTH + STEP_WIDTH,
	localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS   = SPEED_WIDTH + 2 + lsr_pkg::MODE_WIDTH,
	localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// target_rpm, step_count, ramp_time_ms, measured_rpm, now_ms
	input  logic [IN_W-1:0]                  s_tdata,
	// action
	input  logic [lsr_pkg::ACTION_WIDTH-1:0] s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// setpoint_rpm, motor_off, ramp_mode, start_accepted
	output logic [OUT_W-1:0]                 m_tdata
);

	localparam int TW       = lsr_pkg::TIME_WIDTH;
	localparam int OFS_STEP = SPEED_WIDTH;
	localparam int OFS_RAMP = OFS_STEP + STEP_WIDTH;
	localparam int OFS_MEAS = OFS_RAMP + TW;
	localparam int OFS_NOW  = OFS_MEAS + SPEED_WIDTH;

	lsr_pkg::lsr_cmd_t cmd;
	lsr_pkg::lsr_sts_t sts;

	logic [SPEED_WIDTH-1:0]         setpoint_rpm;
	logic                           motor_off;
	logic [lsr_pkg::MODE_WIDTH-1:0] ramp_mode;
	logic                           start_accepted;

	lsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	lsr_dp #(
		.SPEED_WIDTH(SPEED_WIDTH),
		.STEP_WIDTH (STEP_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.action         (s_tuser),
		.target_rpm     (s_tdata[SPEED_WIDTH-1:0]),
		.step_count     (s_tdata[OFS_STEP +: STEP_WIDTH]),
		.ramp_time_ms   (s_tdata[OFS_RAMP +: TW]),
		.measured_rpm   (s_tdata[OFS_MEAS +: SPEED_WIDTH]),
		.now_ms         (s_tdata[OFS_NOW +: TW]),
		.setpoint_rpm   (setpoint_rpm),
		.motor_off      (motor_off),
		.ramp_mode      (ramp_mode),
		.start_accepted (start_accepted)
	);

	// result word, zero padded to whole bytes
	assign m_tdata = OUT_W'({start_accepted, ramp_mode, motor_off, setpoint_rpm});

endmodule
